>>> rtl/sbusrx_pkg.sv
package sbusrx_pkg;

   localparam int FRAME_BYTES = 25;
   localparam int WIN_IDX_W   = $clog2(FRAME_BYTES);
   localparam int FILL_W      = $clog2(FRAME_BYTES + 1);

   localparam int CHANNELS    = 16;
   localparam int CHAN_IDX_W  = 4;
   localparam int CHAN_VAL_W  = 11;
   localparam int BYTE_W      = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [WIN_IDX_W-1:0] FLAG_BYTE_IDX = WIN_IDX_W'(FRAME_BYTES - 2);

   localparam logic [BYTE_W-1:0] FLAG_HIGH_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] HEADER_RESET   = 8'h0F;
   localparam logic [BYTE_W-1:0] FOOTER_RESET   = 8'h00;

   localparam int FLAG_DIGITAL_ONE = 0;
   localparam int FLAG_DIGITAL_TWO = 1;
   localparam int FLAG_LOST_FRAME  = 2;
   localparam int FLAG_FAIL_SAFE   = 3;

   typedef enum logic {
      REG_HEADER = 1'b0,
      REG_FOOTER = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic                 wr_en;
      logic [WIN_IDX_W-1:0] wr_idx;
      logic                 rd_en;
      logic [WIN_IDX_W-1:0] rd_idx;
      logic [WIN_IDX_W-1:0] head;
   } win_ctrl_type;

   // ring position of an offset from the window head
   function automatic logic [WIN_IDX_W-1:0] wrap_add(input logic [WIN_IDX_W-1:0] base,
                                                     input logic [WIN_IDX_W-1:0] off);
      logic [WIN_IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (WIN_IDX_W + 1)'(FRAME_BYTES)) begin
         sum = sum - (WIN_IDX_W + 1)'(FRAME_BYTES);
      end
      return sum[WIN_IDX_W-1:0];
   endfunction

endpackage

>>> rtl/sbusrx_if.sv
interface sbusrx_req_if
   import sbusrx_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbusrx_rsp_if
   import sbusrx_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CHAN_IDX_W-1:0] channel_number;
   logic [CHAN_VAL_W-1:0] channel_value;
   logic                  digital_one;
   logic                  digital_two;
   logic                  lost_frame;
   logic                  fail_safe;
   logic                  frame_end;

   modport source (output valid, output channel_number, output channel_value,
                   output digital_one, output digital_two, output lost_frame,
                   output fail_safe, output frame_end, input ready);
   modport sink   (input valid, input channel_number, input channel_value,
                   input digital_one, input digital_two, input lost_frame,
                   input fail_safe, input frame_end, output ready);
endinterface

>>> rtl/sbusrx_window.sv
module sbusrx_window
   import sbusrx_pkg::*;
(
   input  logic              clock,
   input  win_ctrl_type      ctrl,
   input  logic [BYTE_W-1:0] wr_data,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0]    mem_ff [FRAME_BYTES];
   logic [BYTE_W-1:0]    rd_data_ff;
   logic [WIN_IDX_W-1:0] wr_phys;
   logic [WIN_IDX_W-1:0] rd_phys;

   assign wr_phys = wrap_add(ctrl.head, ctrl.wr_idx);
   assign rd_phys = wrap_add(ctrl.head, ctrl.rd_idx);

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[wr_phys] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem_ff[rd_phys];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sbus_frame_receiver.sv
// A byte that completes no frame keeps ST_IDLE; the next is taken in the following cycle.
// The 25th byte starts the header and flag reads through the single window read port.
// A valid frame then streams 16 channel transactions, each three byte reads and an output
// load; input is held off until the last one is loaded, and a busy output stalls the load.
// An invalid frame resynchronises by reading and comparing stored bytes up to the next header.
// Reset empties the window and restores header 0x0F and footer 0x00; window contents stay.
module sbus_frame_receiver
   import sbusrx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   sbusrx_req_if.sink            req_chan,
   sbusrx_rsp_if.source          rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_HDR,
      ST_RD_FLG,
      ST_CHECK,
      ST_DROP_RD,
      ST_DROP_CMP,
      ST_CH_RD0,
      ST_CH_RD1,
      ST_CH_RD2,
      ST_CH_OUT
   } state_type;

   state_type             state_ff;
   logic [FILL_W-1:0]     fill_ff;
   logic [WIN_IDX_W-1:0]  head_ff;
   logic [FILL_W-1:0]     scan_ff;
   logic [CHAN_IDX_W-1:0] chan_ff;
   logic                  hdr_ok_ff;
   logic                  footer_ok_ff;
   logic [3:0]            flags_ff;
   logic [BYTE_W-1:0]     b0_ff;
   logic [BYTE_W-1:0]     b1_ff;
   logic [BYTE_W-1:0]     header_ff;
   logic [BYTE_W-1:0]     footer_ff;

   logic                  rsp_valid_ff;
   logic [CHAN_IDX_W-1:0] rsp_number_ff;
   logic [CHAN_VAL_W-1:0] rsp_value_ff;
   logic [3:0]            rsp_flags_ff;
   logic                  rsp_end_ff;

   win_ctrl_type          win_ctrl;
   logic [BYTE_W-1:0]     rd_data;
   logic                  req_accept;
   logic                  req_keep;
   logic [FILL_W-1:0]     fill_in;
   logic                  rsp_load;
   logic                  frame_ok;
   logic                  csr_write;
   csr_reg_type           csr_sel;
   logic [7:0]            bitpos;
   logic [WIN_IDX_W-1:0]  chan_idx;
   logic [2:0]            chan_shift;
   logic [23:0]           chan_word;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   // drop stray bytes while the window is empty
   assign req_keep       = req_accept && !(fill_ff == '0 && req_chan.rx_byte != header_ff);
   assign fill_in        = fill_ff + FILL_W'(1);

   assign bitpos     = 8'({chan_ff, 3'b000}) + 8'({chan_ff, 1'b0}) + 8'(chan_ff);
   assign chan_idx   = WIN_IDX_W'(bitpos[7:3]) + WIN_IDX_W'(1);
   assign chan_shift = bitpos[2:0];
   assign chan_word  = {rd_data, b1_ff, b0_ff};

   assign frame_ok = hdr_ok_ff && footer_ok_ff && ((rd_data & FLAG_HIGH_MASK) == '0);
   assign rsp_load = (state_ff == ST_CH_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      win_ctrl        = '0;
      win_ctrl.head   = head_ff;
      win_ctrl.wr_en  = req_keep;
      win_ctrl.wr_idx = fill_ff[WIN_IDX_W-1:0];
      unique case (state_ff)
         ST_RD_HDR: begin
            win_ctrl.rd_en  = 1'b1;
            win_ctrl.rd_idx = '0;
         end
         ST_RD_FLG: begin
            win_ctrl.rd_en  = 1'b1;
            win_ctrl.rd_idx = FLAG_BYTE_IDX;
         end
         ST_DROP_RD: begin
            win_ctrl.rd_en  = (scan_ff < fill_ff);
            win_ctrl.rd_idx = scan_ff[WIN_IDX_W-1:0];
         end
         ST_CH_RD0: begin
            win_ctrl.rd_en  = 1'b1;
            win_ctrl.rd_idx = chan_idx;
         end
         ST_CH_RD1: begin
            win_ctrl.rd_en  = 1'b1;
            win_ctrl.rd_idx = chan_idx + WIN_IDX_W'(1);
         end
         ST_CH_RD2: begin
            win_ctrl.rd_en  = 1'b1;
            win_ctrl.rd_idx = chan_idx + WIN_IDX_W'(2);
         end
         default: begin
            win_ctrl.rd_en = 1'b0;
         end
      endcase
   end

   sbusrx_window u_window (
      .clock   (clock),
      .ctrl    (win_ctrl),
      .wr_data (req_chan.rx_byte),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register: hold until taken
         if (rsp_load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_number_ff <= chan_ff;
            rsp_value_ff  <= CHAN_VAL_W'(chan_word >> chan_shift);
            rsp_flags_ff  <= flags_ff;
            rsp_end_ff    <= (chan_ff == CHAN_IDX_W'(CHANNELS - 1));
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_keep) begin
                  fill_ff <= fill_in;
                  if (fill_in == FILL_W'(FRAME_BYTES)) begin
                     footer_ok_ff <= (req_chan.rx_byte == footer_ff);
                     state_ff     <= ST_RD_HDR;
                  end
               end
            end
            ST_RD_HDR: begin
               state_ff <= ST_RD_FLG;
            end
            ST_RD_FLG: begin
               hdr_ok_ff <= (rd_data == header_ff);
               state_ff  <= ST_CHECK;
            end
            ST_CHECK: begin
               flags_ff <= rd_data[3:0];
               if (frame_ok) begin
                  chan_ff  <= '0;
                  state_ff <= ST_CH_RD0;
               end else begin
                  scan_ff  <= FILL_W'(1);
                  state_ff <= ST_DROP_RD;
               end
            end
            ST_DROP_RD: begin
               if (scan_ff >= fill_ff) begin
                  fill_ff  <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_DROP_CMP;
               end
            end
            ST_DROP_CMP: begin
               // advance the head to the next stored header byte
               if (rd_data == header_ff) begin
                  head_ff  <= wrap_add(head_ff, scan_ff[WIN_IDX_W-1:0]);
                  fill_ff  <= fill_ff - scan_ff;
                  state_ff <= ST_IDLE;
               end else begin
                  scan_ff  <= scan_ff + FILL_W'(1);
                  state_ff <= ST_DROP_RD;
               end
            end
            ST_CH_RD0: begin
               state_ff <= ST_CH_RD1;
            end
            ST_CH_RD1: begin
               b0_ff    <= rd_data;
               state_ff <= ST_CH_RD2;
            end
            ST_CH_RD2: begin
               b1_ff    <= rd_data;
               state_ff <= ST_CH_OUT;
            end
            ST_CH_OUT: begin
               if (rsp_load) begin
                  if (chan_ff == CHAN_IDX_W'(CHANNELS - 1)) begin
                     fill_ff  <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     chan_ff  <= chan_ff + CHAN_IDX_W'(1);
                     state_ff <= ST_CH_RD0;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.channel_number = rsp_number_ff;
   assign rsp_chan.channel_value  = rsp_value_ff;
   assign rsp_chan.digital_one    = rsp_flags_ff[FLAG_DIGITAL_ONE];
   assign rsp_chan.digital_two    = rsp_flags_ff[FLAG_DIGITAL_TWO];
   assign rsp_chan.lost_frame     = rsp_flags_ff[FLAG_LOST_FRAME];
   assign rsp_chan.fail_safe      = rsp_flags_ff[FLAG_FAIL_SAFE];
   assign rsp_chan.frame_end      = rsp_end_ff;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_sel   = csr_reg_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         footer_ff <= FOOTER_RESET;
      end else if (csr_write) begin
         unique case (csr_sel)
            REG_HEADER: header_ff <= pwdata[BYTE_W-1:0];
            REG_FOOTER: footer_ff <= pwdata[BYTE_W-1:0];
            default:    header_ff <= header_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_HEADER: prdata = CSR_DATA_W'(header_ff);
         REG_FOOTER: prdata = CSR_DATA_W'(footer_ff);
         default:    prdata = '0;
      endcase
   end

`ifndef SYNTHESIS
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(FRAME_BYTES))
      else $error("window fill beyond frame length");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff < WIN_IDX_W'(FRAME_BYTES))
      else $error("window head outside ring");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DROP_CMP |-> scan_ff < fill_ff && scan_ff != '0)
      else $error("resync scan outside stored bytes");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_valid_ff |-> rsp_chan.ready)
      else $error("pending transaction overwritten");

   a_full_checks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD_HDR |-> fill_ff == FILL_W'(FRAME_BYTES))
      else $error("frame check started on partial window");
`endif

endmodule
